### sv/tcal_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar fields: shared package
// Constants, reciprocal multipliers, the month start table and the pipeline
// stage and control types.
// ----------------------------------------------------------------------------
package tcal_pkg;

   localparam int unsigned NUM_STAGES = 17;

   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 56;

   localparam int unsigned MS_PER_SEC = 1000;
   localparam int unsigned SEC_DIV    = 675;
   localparam int unsigned ERA_DAYS   = 146097;
   localparam int unsigned SHIFT_DAYS = 719468 - 25567;
   localparam int unsigned CENT_DAYS  = 36524;
   localparam int unsigned QUAD_DAYS  = 1460;
   localparam int unsigned YEAR_DAYS  = 365;
   localparam int unsigned MP_DIV     = 153;

   // Each is floor(2^s / d), where s is the width of the dividend.
   localparam int unsigned RECIP_1000_HI = 2097;
   localparam int unsigned RECIP_1000_LO = 2147483;
   localparam int unsigned RECIP_675     = 49710;
   localparam int unsigned RECIP_15      = 2184;
   localparam int unsigned RECIP_7       = 18724;
   localparam int unsigned RECIP_60      = 34;
   localparam int unsigned RECIP_1460    = 179;
   localparam int unsigned RECIP_365     = 718;
   localparam int unsigned RECIP_153     = 13;

   localparam logic [8:0] MONTH_START [16] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153, 9'd184, 9'd214,
      9'd245, 9'd275, 9'd306, 9'd337, 9'd0, 9'd0, 9'd0, 9'd0
   };

   typedef struct packed {
      logic [41:0] ms;
      logic [11:0] qh;
      logic [9:0]  rh;
      logic [20:0] ql;
      logic [31:0] secs;
      logic [9:0]  msec;
      logic [15:0] days;
      logic [16:0] rem;
      logic [19:0] z;
      logic [10:0] tmin;
      logic [13:0] wq;
      logic [2:0]  weekday;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  era;
      logic [17:0] doe;
      logic [7:0]  a;
      logic [2:0]  b;
      logic        c;
      logic [17:0] t;
      logic [8:0]  yoe;
      logic [8:0]  doy;
      logic [3:0]  mp;
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
   } stage_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

### sv/tcal_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar fields: pipeline control
// Per-stage valid bits and load enables. A stage loads when it is empty or
// when the stage after it loads, so bubbles are squeezed out under stall.
// ----------------------------------------------------------------------------
module tcal_pipe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      out_ready,
   output tcal_pkg::pipe_ctrl_type   ctrl
);
   import tcal_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign valid_in   = {valid_ff[NUM_STAGES-2:0], in_valid};
   assign in_ready   = load[0];
   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

endmodule

### sv/timestamp_to_calendar_fields.sv
// Throughput: one transaction per cycle while the response stream does not
// stall. Each constant-divisor step is a reciprocal multiply in a stage
// and a compare-and-subtract correction in the stage after it.
// Stalls squeeze out bubbles, so requests are taken while a result waits.
// Reset clears the stage valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
// Timestamp to calendar fields
// Converts milliseconds since 1900-01-01 into Gregorian date, time of day
// and weekday using the 400-year era method on a day count from 0000-03-01.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_fields (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [41:0] ms_since_1900
   input  logic [tcal_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [10:0] year, [14:11] month, [19:15] day_of_month, [24:20] hour,
   // [30:25] minute, [36:31] second, [46:37] millisecond, [49:47] weekday
   output logic [tcal_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import tcal_pkg::*;

   pipe_ctrl_type ctrl;
   stage_type     stage_ff [NUM_STAGES];
   stage_type     stage_in [NUM_STAGES];
   stage_type     rsp_stage;

   tcal_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   always_comb begin
      logic [32:0] p0;
      logic [21:0] p1;
      logic [10:0] d1;
      logic [30:0] v2;
      logic [52:0] p2;
      logic [30:0] v3;
      logic [30:0] p3;
      logic [10:0] d3;
      logic [40:0] p4;
      logic [25:0] p5;
      logic [10:0] d5;
      logic [9:0]  r5;
      logic [26:0] p6m;
      logic [16:0] d6;
      logic [31:0] p6w;
      logic [14:0] p7m;
      logic [4:0]  d7m;
      logic [16:0] p7w;
      logic [3:0]  d7w;
      logic [16:0] p8h;
      logic [25:0] p8a;
      logic [10:0] p9h;
      logic [6:0]  d9h;
      logic [18:0] p9a;
      logic [11:0] d9a;
      logic [27:0] p11;
      logic [17:0] p12;
      logic [9:0]  d12;
      logic [1:0]  c100;
      logic [17:0] base13;
      logic [10:0] n14;
      logic [14:0] p14;
      logic [10:0] n15;
      logic [10:0] p15;
      logic [8:0]  d15;
      logic [3:0]  m16;

      // Split the upper 21 bits by 1000.
      stage_in[0]    = '0;
      stage_in[0].ms = req_tdata[41:0];
      p0             = 33'(req_tdata[41:21]) * 33'(RECIP_1000_HI);
      stage_in[0].qh = p0[32:21];

      stage_in[1] = stage_ff[0];
      p1 = 22'(stage_ff[0].qh) * 22'(MS_PER_SEC);
      d1 = 11'(22'(stage_ff[0].ms[41:21]) - p1);
      if (d1 >= 11'(MS_PER_SEC)) begin
         stage_in[1].qh = stage_ff[0].qh + 12'd1;
         stage_in[1].rh = 10'(d1 - 11'(MS_PER_SEC));
      end else begin
         stage_in[1].rh = d1[9:0];
      end

      // Remainder with the lower 21 bits, split by 1000 again.
      stage_in[2] = stage_ff[1];
      v2 = {stage_ff[1].rh, stage_ff[1].ms[20:0]};
      p2 = 53'(v2) * 53'(RECIP_1000_LO);
      stage_in[2].ql = p2[51:31];

      stage_in[3] = stage_ff[2];
      v3 = {stage_ff[2].rh, stage_ff[2].ms[20:0]};
      p3 = 31'(stage_ff[2].ql) * 31'(MS_PER_SEC);
      d3 = 11'(v3 - p3);
      if (d3 >= 11'(MS_PER_SEC)) begin
         stage_in[3].ql   = stage_ff[2].ql + 21'd1;
         stage_in[3].msec = 10'(d3 - 11'(MS_PER_SEC));
      end else begin
         stage_in[3].msec = d3[9:0];
      end
      stage_in[3].secs = {stage_ff[2].qh[10:0], stage_in[3].ql};

      // Seconds per day is 128 * 675.
      stage_in[4] = stage_ff[3];
      p4 = 41'(stage_ff[3].secs[31:7]) * 41'(RECIP_675);
      stage_in[4].days = p4[40:25];

      stage_in[5] = stage_ff[4];
      p5 = 26'(stage_ff[4].days) * 26'(SEC_DIV);
      d5 = 11'(26'(stage_ff[4].secs[31:7]) - p5);
      if (d5 >= 11'(SEC_DIV)) begin
         stage_in[5].days = stage_ff[4].days + 16'd1;
         r5 = 10'(d5 - 11'(SEC_DIV));
      end else begin
         r5 = d5[9:0];
      end
      stage_in[5].rem = {r5, stage_ff[4].secs[6:0]};

      stage_in[6] = stage_ff[5];
      stage_in[6].z = 20'(stage_ff[5].days) + 20'(SHIFT_DAYS);
      p6m = 27'(stage_ff[5].rem[16:2]) * 27'(RECIP_15);
      stage_in[6].tmin = p6m[25:15];
      d6  = 17'(stage_ff[5].days) + 17'd1;
      p6w = 32'(d6) * 32'(RECIP_7);
      stage_in[6].wq = p6w[30:17];

      stage_in[7] = stage_ff[6];
      p7m = 15'(stage_ff[6].tmin) * 15'(15);
      d7m = 5'(15'(stage_ff[6].rem[16:2]) - p7m);
      if (d7m >= 5'd15) begin
         stage_in[7].tmin   = stage_ff[6].tmin + 11'd1;
         stage_in[7].second = {4'(d7m - 5'd15), stage_ff[6].rem[1:0]};
      end else begin
         stage_in[7].second = {d7m[3:0], stage_ff[6].rem[1:0]};
      end
      p7w = 17'(stage_ff[6].wq) * 17'(7);
      d7w = 4'(17'(stage_ff[6].days) + 17'd1 - p7w);
      if (d7w >= 4'd7) begin
         stage_in[7].weekday = 3'(d7w - 4'd7);
      end else begin
         stage_in[7].weekday = d7w[2:0];
      end
      // The day count always lies in era 4 or era 5.
      if (stage_ff[6].z >= 20'(5 * ERA_DAYS)) begin
         stage_in[7].era = 3'd5;
         stage_in[7].doe = 18'(stage_ff[6].z - 20'(5 * ERA_DAYS));
      end else begin
         stage_in[7].era = 3'd4;
         stage_in[7].doe = 18'(stage_ff[6].z - 20'(4 * ERA_DAYS));
      end

      stage_in[8] = stage_ff[7];
      p8h = 17'(stage_ff[7].tmin) * 17'(RECIP_60);
      stage_in[8].hour = p8h[15:11];
      p8a = 26'(stage_ff[7].doe) * 26'(RECIP_1460);
      stage_in[8].a = p8a[25:18];
      stage_in[8].b = 3'(stage_ff[7].doe >= 18'(CENT_DAYS))
                    + 3'(stage_ff[7].doe >= 18'(2 * CENT_DAYS))
                    + 3'(stage_ff[7].doe >= 18'(3 * CENT_DAYS))
                    + 3'(stage_ff[7].doe >= 18'(4 * CENT_DAYS));
      stage_in[8].c = (stage_ff[7].doe == 18'(ERA_DAYS - 1));

      stage_in[9] = stage_ff[8];
      p9h = 11'(stage_ff[8].hour) * 11'(60);
      d9h = 7'(11'(stage_ff[8].tmin) - p9h);
      if (d9h >= 7'd60) begin
         stage_in[9].hour   = stage_ff[8].hour + 5'd1;
         stage_in[9].minute = 6'(d9h - 7'd60);
      end else begin
         stage_in[9].minute = d9h[5:0];
      end
      p9a = 19'(stage_ff[8].a) * 19'(QUAD_DAYS);
      d9a = 12'(19'(stage_ff[8].doe) - p9a);
      if (d9a >= 12'(QUAD_DAYS)) begin
         stage_in[9].a = stage_ff[8].a + 8'd1;
      end

      stage_in[10] = stage_ff[9];
      stage_in[10].t = stage_ff[9].doe - 18'(stage_ff[9].a)
                     + 18'(stage_ff[9].b) - 18'(stage_ff[9].c);

      stage_in[11] = stage_ff[10];
      p11 = 28'(stage_ff[10].t) * 28'(RECIP_365);
      stage_in[11].yoe = p11[26:18];

      stage_in[12] = stage_ff[11];
      p12 = 18'(stage_ff[11].yoe) * 18'(YEAR_DAYS);
      d12 = 10'(stage_ff[11].t - p12);
      if (d12 >= 10'(YEAR_DAYS)) begin
         stage_in[12].yoe = stage_ff[11].yoe + 9'd1;
      end

      stage_in[13] = stage_ff[12];
      c100 = 2'(stage_ff[12].yoe >= 9'd100) + 2'(stage_ff[12].yoe >= 9'd200)
           + 2'(stage_ff[12].yoe >= 9'd300);
      base13 = 18'(stage_ff[12].yoe) * 18'(YEAR_DAYS)
             + 18'(stage_ff[12].yoe[8:2]) - 18'(c100);
      stage_in[13].doy = 9'(stage_ff[12].doe - base13);

      stage_in[14] = stage_ff[13];
      n14 = {stage_ff[13].doy, 2'b00} + 11'(stage_ff[13].doy) + 11'd2;
      p14 = 15'(n14) * 15'(RECIP_153);
      stage_in[14].mp = p14[14:11];

      stage_in[15] = stage_ff[14];
      n15 = {stage_ff[14].doy, 2'b00} + 11'(stage_ff[14].doy) + 11'd2;
      p15 = 11'(stage_ff[14].mp) * 11'(MP_DIV);
      d15 = 9'(n15 - p15);
      if (d15 >= 9'(MP_DIV)) begin
         stage_in[15].mp = stage_ff[14].mp + 4'd1;
      end

      stage_in[16] = stage_ff[15];
      if (stage_ff[15].mp < 4'd10) begin
         m16 = stage_ff[15].mp + 4'd3;
      end else begin
         m16 = stage_ff[15].mp - 4'd9;
      end
      stage_in[16].month        = m16;
      stage_in[16].day_of_month = 5'(stage_ff[15].doy - MONTH_START[stage_ff[15].mp] + 9'd1);
      stage_in[16].year = 11'(stage_ff[15].yoe) + 11'(stage_ff[15].era) * 11'd400
                        + ((m16 <= 4'd2) ? 11'd1 : 11'd0);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ctrl.load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_stage  = stage_ff[NUM_STAGES-1];
   assign rsp_tvalid = ctrl.valid[NUM_STAGES-1];
   assign rsp_tdata  = {6'd0, rsp_stage.weekday, rsp_stage.msec, rsp_stage.second,
                        rsp_stage.minute, rsp_stage.hour, rsp_stage.day_of_month,
                        rsp_stage.month, rsp_stage.year};

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_stage.month >= 4'd1 && rsp_stage.month <= 4'd12))
      else $error("Month out of range.");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_stage.day_of_month >= 5'd1 && rsp_stage.weekday <= 3'd6))
      else $error("Day of month or weekday out of range.");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_stage.hour <= 5'd23 && rsp_stage.minute <= 6'd59
                      && rsp_stage.second <= 6'd59 && rsp_stage.msec <= 10'd999))
      else $error("Time of day out of range.");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_stage.year >= 11'd1900 && rsp_stage.year <= 11'd2036))
      else $error("Year out of range.");

endmodule

### tb/sv/tb_timestamp_to_calendar_fields.sv
// ----------------------------------------------------------------------------
// Testbench: timestamp to calendar fields
// Sends millisecond timestamps through the request stream and compares every
// response field with fixed values or a testbench calendar function. A short
// table covers the field extremes, leap and century days and the 2036 wrap.
// Random timestamps follow, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_timestamp_to_calendar_fields;

   timeunit 1ns;
   timeprecision 1ps;

   import tcal_pkg::*;

   localparam longint unsigned TS_MAX      = 64'd4294967295999;
   localparam int unsigned     CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [2:0]  weekday;
      logic [9:0]  millisecond;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [10:0] year;
   } cal_fields_type;

   typedef struct {
      logic [41:0]    ms;
      bit             typed;
      cal_fields_type fields;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   cal_fields_type calendar_q[$];
   bit             row_typed;
   cal_fields_type row_fields;
   bit             quiet_stretch = 1'b0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;
   stim_row_type   directed_rows [18];

   timestamp_to_calendar_fields DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic cal_fields_type make_fields(input int unsigned yr, mo, dy, hr, mn, sc,
                                                  msec, wd);
      cal_fields_type f;
      f.year = 11'(yr);
      f.month = 4'(mo);
      f.day_of_month = 5'(dy);
      f.hour = 5'(hr);
      f.minute = 6'(mn);
      f.second = 6'(sc);
      f.millisecond = 10'(msec);
      f.weekday = 3'(wd);
      return f;
   endfunction

   // Civil date from a day count shifted to 0000-03-01, in 400-year eras.
   function automatic cal_fields_type civil_fields(input logic [41:0] ms);
      longint unsigned total;
      int unsigned     secs, days, tod, z, era, doe, yoe, doy, mp;
      cal_fields_type  f;
      total = 64'(ms);
      f.millisecond = 10'(total % 1000);
      secs = 32'(total / 1000);
      days = secs / 86400;
      tod = secs % 86400;
      f.hour = 5'(tod / 3600);
      f.minute = 6'((tod / 60) % 60);
      f.second = 6'(tod % 60);
      f.weekday = 3'((days + 1) % 7);
      z = days - 25567 + 719468;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      f.month = 4'((mp < 10) ? mp + 3 : mp - 9);
      f.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
      f.year = 11'(yoe + era * 400 + ((f.month <= 2) ? 1 : 0));
      return f;
   endfunction

   function automatic bit idle_draw();
      return !quiet_stretch && ($urandom_range(0, 99) < 15);
   endfunction

   function automatic logic [41:0] random_timestamp();
      logic [63:0]     r;
      longint unsigned day;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0: return r[41:0];
         1, 2: begin
            day = $urandom_range(0, 49709);
            if (r[63])
               return 42'(day * 86400000 + $urandom_range(0, 1999));
            else
               return 42'(day * 86400000 + 86399999 - $urandom_range(0, 1999));
         end
         default: return 42'(r % (TS_MAX + 1));
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned expected,
                                       input int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   task automatic send_timestamp(input logic [41:0] ms, input bit typed,
                                 input cal_fields_type fields);
      while (idle_draw()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'(ms);
      row_typed <= typed;
      row_fields <= fields;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (calendar_q.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= !idle_draw();
   end

   always @(posedge clock) begin
      cal_fields_type got, want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = cal_fields_type'(rsp_tdata[49:0]);
            if (calendar_q.size() == 0) begin
               $error("Response transaction with no request outstanding.");
               error_count++;
            end else begin
               want = calendar_q.pop_front();
               check_field("year", want.year, got.year);
               check_field("month", want.month, got.month);
               check_field("day_of_month", want.day_of_month, got.day_of_month);
               check_field("hour", want.hour, got.hour);
               check_field("minute", want.minute, got.minute);
               check_field("second", want.second, got.second);
               check_field("millisecond", want.millisecond, got.millisecond);
               check_field("weekday", want.weekday, got.weekday);
            end
         end
         if (req_tvalid && req_tready)
            calendar_q.push_back(row_typed ? row_fields : civil_fields(req_tdata[41:0]));
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      row_typed = 1'b0;
      row_fields = '0;
      directed_rows = '{
         '{42'd0,             1'b1, make_fields(1900, 1, 1, 0, 0, 0, 0, 1)},
         '{42'd999,           1'b0, '0},
         '{42'd1000,          1'b0, '0},
         '{42'd59999,         1'b0, '0},
         '{42'd3599999,       1'b0, '0},
         '{42'd86399999,      1'b0, '0},
         '{42'd86400000,      1'b0, '0},
         '{42'd5097599999,    1'b0, '0},
         '{42'd5097600000,    1'b0, '0},
         '{42'd2208988800000, 1'b1, make_fields(1970, 1, 1, 0, 0, 0, 0, 4)},
         '{42'd3155673599999, 1'b1, make_fields(1999, 12, 31, 23, 59, 59, 999, 5)},
         '{42'd3160816496789, 1'b1, make_fields(2000, 2, 29, 12, 34, 56, 789, 2)},
         '{42'd3160857600000, 1'b0, '0},
         '{42'd4294967295999, 1'b1, make_fields(2036, 2, 7, 6, 28, 15, 999, 4)},
         '{42'd4294967296000, 1'b1, make_fields(1900, 1, 1, 0, 0, 0, 0, 1)},
         '{42'h3FF_FFFF_FFFF, 1'b0, '0},
         '{42'h2AA_AAAA_AAAA, 1'b0, '0},
         '{42'h155_5555_5555, 1'b0, '0}
      };
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i])
         send_timestamp(directed_rows[i].ms, directed_rows[i].typed, directed_rows[i].fields);
      wait_drained();
      for (int i = 0; i < 500; i++) begin
         quiet_stretch = (i >= 150) && (i < 300);
         if (i == 300)
            wait_drained();
         send_timestamp(random_timestamp(), 1'b0, '0);
      end
      wait_drained();
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
